/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define TVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tvs assertion failed");

// property that must hold in the cycle after a stalled transaction
`define TVS_ASSERT_STALL(lbl, clk, rst_n, vld, rdy, prop) \
    `TVS_ASSERT(lbl, clk, rst_n, (vld) && !(rdy) |=> (prop))

`endif

/* hw/rtl/tvs_pkg.sv */
// ----------------------------------------------------------------------------
// tvs_pkg
// Widths, angle constants, command codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tvs_pkg;

    localparam int CMD_W    = 2;
    localparam int COORD_W  = 32;
    localparam int TURN_W   = 26;
    localparam int HEAD_W   = 25;
    localparam int ANG_W    = 27;
    localparam int VEC_W    = 34;
    localparam int ATAN_W   = 22;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int FRAC_VEC = 30;

    localparam int TABLE_LEN        = 24;
    localparam int CNT_W            = $clog2(TABLE_LEN);
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG270 = 27'sd17694720;
    localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;

    localparam logic signed [COORD_W-1:0] GAIN_Q30 = 32'sd652032874;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD  = 2'd0,
        CMD_TURN = 2'd1,
        CMD_SET  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] cos_v;
        logic signed [COORD_W-1:0] sin_v;
    } cordic_res_t;

    // round(atan(2^-i) in degrees, Q16.16)
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/tvs_if.sv */
// ----------------------------------------------------------------------------
// tvs_if
// Valid/ready channels for turtle commands and emitted segments.
// ----------------------------------------------------------------------------
interface tvs_cmd_if;
    import tvs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] distance;
    logic                      draw_line;
    logic signed [TURN_W-1:0]  turn_degrees;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;

    modport source (
        output valid, command, distance, draw_line, turn_degrees, target_x, target_y,
        input  ready
    );
    modport sink (
        input  valid, command, distance, draw_line, turn_degrees, target_x, target_y,
        output ready
    );
endinterface

interface tvs_seg_if;
    import tvs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

/* hw/rtl/tvs_cordic.sv */
// ----------------------------------------------------------------------------
// tvs_cordic
// Iterative CORDIC rotation: one shift-add step per cycle, gives cos and sin
// of a heading in Q2.30.
// ----------------------------------------------------------------------------
module tvs_cordic #(
    parameter int STEPS = tvs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tvs_pkg::HEAD_W-1:0]      angle,
    output tvs_pkg::cordic_res_t            res
);
    import tvs_pkg::*;

    localparam int EFF_STEPS = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(EFF_STEPS - 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      neg_reg, neg_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [VEC_W-1:0]   x_reg, x_next;
    logic signed [VEC_W-1:0]   y_reg, y_next;
    logic signed [ANG_W-1:0]   z_reg, z_next;

    logic signed [ANG_W-1:0]   ang;
    logic signed [VEC_W-1:0]   xs;
    logic signed [VEC_W-1:0]   ys;
    logic signed [ANG_W-1:0]   at;

    assign ang = signed'({2'b00, angle});
    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign at  = signed'({{(ANG_W-ATAN_W){1'b0}}, atan_q16(cnt_reg)});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = VEC_W'(GAIN_Q30);
            y_next    = '0;
            // fold into [-90, 90] degrees
            if (ang > DEG90 && ang <= DEG270)
            begin
                z_next   = ang - DEG180;
                neg_next = 1'b1;
            end
            else if (ang > DEG270)
            begin
                z_next   = ang - DEG360;
                neg_next = 1'b0;
            end
            else
            begin
                z_next   = ang;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign res.done  = done_reg;
    assign res.cos_v = neg_reg ? COORD_W'(-x_reg) : COORD_W'(x_reg);
    assign res.sin_v = neg_reg ? COORD_W'(-y_reg) : COORD_W'(y_reg);

endmodule

/* hw/rtl/tvs_mac.sv */
// ----------------------------------------------------------------------------
// tvs_mac
// Shared multiplier with registered product, round half up to Q16.16 and
// saturating add to a pen coordinate.
// ----------------------------------------------------------------------------
module tvs_mac (
    input  logic                               clk,
    input  logic                               mul_en,
    input  logic signed [tvs_pkg::COORD_W-1:0] step_len,
    input  logic signed [tvs_pkg::COORD_W-1:0] coef,
    input  logic signed [tvs_pkg::COORD_W-1:0] pen,
    output logic signed [tvs_pkg::COORD_W-1:0] sum_sat
);
    import tvs_pkg::*;

    localparam int SUM_W = COORD_W + 3;
    localparam int DEL_W = PROD_W - FRAC_VEC;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;
    logic signed [DEL_W-1:0]  delta;
    logic signed [SUM_W-1:0]  sum;

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= step_len * coef;
    end

    assign rnd   = prod_reg + (PROD_W'(1) <<< (FRAC_VEC - 1));
    assign delta = rnd[PROD_W-1:FRAC_VEC];
    assign sum   = {{(SUM_W-COORD_W){pen[COORD_W-1]}}, pen}
                 + {{(SUM_W-DEL_W){delta[DEL_W-1]}}, delta};

    always_comb
    begin
        if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1)
            sum_sat = sum[COORD_W-1:0];
        else if (sum[SUM_W-1])
            sum_sat = {1'b1, {(COORD_W-1){1'b0}}};
        else
            sum_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end

endmodule

/* hw/rtl/turtle_vector_step_top.sv */
// Forward move: the command runs through S_ROT, S_MULX, S_MULY, S_SUMY and S_EMIT;
//   the segment is registered in S_EMIT and the next command is taken back in S_IDLE,
//   paced by the one-step-per-cycle CORDIC loop and the shared multiplier (2 passes).
// Turn: modulo-360 wrap in S_WRAP, one add or subtract per cycle, then back to S_IDLE.
// Set position and unused codes: pass through S_DONE. A held segment stalls only the next draw.
// Reset (async, active low): pen at origin, heading 0 degrees, no segment pending.
// ----------------------------------------------------------------------------
// turtle_vector_step_top
// Turtle-graphics line generator with pen position, heading and CORDIC.
// ----------------------------------------------------------------------------
module turtle_vector_step_top #(
    parameter int CORDIC_STEPS = tvs_pkg::CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tvs_cmd_if.sink   cmd,
    tvs_seg_if.source seg
);
    import tvs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ROT  = 8'b0000_0010,
        S_MULX = 8'b0000_0100,
        S_MULY = 8'b0000_1000,
        S_SUMY = 8'b0001_0000,
        S_EMIT = 8'b0010_0000,
        S_WRAP = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [COORD_W-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_W-1:0] pen_y_reg, pen_y_next;
    logic [HEAD_W-1:0]         heading_reg, heading_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [ANG_W-1:0]   h_reg, h_next;
    logic signed [COORD_W-1:0] dist_reg, dist_next;
    logic                      draw_reg, draw_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next;
    logic signed [COORD_W-1:0] ny_reg, ny_next;
    logic signed [COORD_W-1:0] sx_reg, sx_next;
    logic signed [COORD_W-1:0] sy_reg, sy_next;
    logic signed [COORD_W-1:0] ex_reg, ex_next;
    logic signed [COORD_W-1:0] ey_reg, ey_next;

    logic                      accept;
    logic                      cordic_start;
    cordic_res_t               cres;
    logic                      mul_en;
    logic signed [COORD_W-1:0] mac_coef;
    logic signed [COORD_W-1:0] mac_pen;
    logic signed [COORD_W-1:0] mac_sum;
    logic                      out_free;

    assign cmd.ready    = (state_reg == S_IDLE);
    assign accept       = cmd.valid && cmd.ready;
    assign cordic_start = accept && (cmd.command == CMD_FWD);
    assign out_free     = !out_valid_reg || seg.ready;

    tvs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (heading_reg),
        .res   (cres)
    );

    assign mul_en   = (state_reg == S_MULX) || (state_reg == S_MULY);
    assign mac_coef = (state_reg == S_MULX) ? cres.cos_v : cres.sin_v;
    assign mac_pen  = (state_reg == S_MULY) ? pen_x_reg : pen_y_reg;

    tvs_mac u_mac (
        .clk      (clk),
        .mul_en   (mul_en),
        .step_len (dist_reg),
        .coef     (mac_coef),
        .pen      (mac_pen),
        .sum_sat  (mac_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg && !seg.ready;
        h_next         = h_reg;
        dist_next      = dist_reg;
        draw_next      = draw_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.command)
                        CMD_FWD:
                        begin
                            dist_next  = cmd.distance;
                            draw_next  = cmd.draw_line;
                            state_next = S_ROT;
                        end
                        CMD_TURN:
                        begin
                            h_next = signed'({2'b00, heading_reg})
                                   + {cmd.turn_degrees[TURN_W-1], cmd.turn_degrees};
                            state_next = S_WRAP;
                        end
                        CMD_SET:
                        begin
                            pen_x_next = cmd.target_x;
                            pen_y_next = cmd.target_y;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                if (cres.done)
                    state_next = S_MULX;
            end
            S_MULX:
            begin
                state_next = S_MULY;
            end
            S_MULY:
            begin
                nx_next    = mac_sum;
                state_next = S_SUMY;
            end
            S_SUMY:
            begin
                ny_next    = mac_sum;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!draw_reg || out_free)
                begin
                    if (draw_reg)
                    begin
                        sx_next        = pen_x_reg;
                        sy_next        = pen_y_reg;
                        ex_next        = nx_reg;
                        ey_next        = ny_reg;
                        out_valid_next = 1'b1;
                    end
                    pen_x_next = nx_reg;
                    pen_y_next = ny_reg;
                    state_next = S_IDLE;
                end
            end
            S_WRAP:
            begin
                if (h_reg < 0)
                    h_next = h_reg + DEG360;
                else if (h_reg >= DEG360)
                    h_next = h_reg - DEG360;
                else
                begin
                    heading_next = h_reg[HEAD_W-1:0];
                    state_next   = S_IDLE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        dist_reg <= dist_next;
        draw_reg <= draw_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
    end

    assign seg.valid   = out_valid_reg;
    assign seg.start_x = sx_reg;
    assign seg.start_y = sy_reg;
    assign seg.end_x   = ex_reg;
    assign seg.end_y   = ey_reg;

endmodule

/* hw/rtl/tvs_checker.sv */
// ----------------------------------------------------------------------------
// tvs_checker
// Port-level checks on the turtle line generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [tvs_pkg::COORD_W-1:0] out_start_x,
    input logic signed [tvs_pkg::COORD_W-1:0] out_start_y,
    input logic signed [tvs_pkg::COORD_W-1:0] out_end_x,
    input logic signed [tvs_pkg::COORD_W-1:0] out_end_y
);

    `TVS_ASSERT_STALL(a_out_hold, clk, rst_n, out_valid, out_ready, out_valid)

    `TVS_ASSERT_STALL(a_out_stable, clk, rst_n, out_valid, out_ready,
        $stable(out_start_x) && $stable(out_start_y) &&
        $stable(out_end_x) && $stable(out_end_y))

    // the block is not ready in the cycle after a command transaction
    `TVS_ASSERT(a_busy_after_cmd, clk, rst_n, in_valid && in_ready |=> !in_ready)

    // a segment never appears right after a command transaction
    `TVS_ASSERT(a_seg_not_early, clk, rst_n, $rose(out_valid) |-> !$past(in_valid && in_ready))

endmodule

bind turtle_vector_step_top tvs_checker u_tvs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .out_valid   (seg.valid),
    .out_ready   (seg.ready),
    .out_start_x (seg.start_x),
    .out_start_y (seg.start_y),
    .out_end_x   (seg.end_x),
    .out_end_y   (seg.end_y)
);

/* sim/tb_turtle_vector_step_top.sv */
// ----------------------------------------------------------------------------
// tb_turtle_vector_step_top
// Drives turtle commands through the valid/ready command channel and checks
// every emitted segment against a fixed-point model of pen, heading and
// CORDIC kept in the bench. A short table of directed commands comes first,
// then random traffic with bursty sending and an irregular segment consumer.
// ----------------------------------------------------------------------------
module tb_turtle_vector_step_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tvs_pkg::*;

    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int RANDOM_ITEMS = 1125;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
    localparam logic signed [TURN_W-1:0]  T45   = 26'sd2949120;
    localparam logic signed [TURN_W-1:0]  T90   = TURN_W'(DEG90);
    localparam logic signed [TURN_W-1:0]  T180  = TURN_W'(DEG180);
    localparam logic signed [TURN_W-1:0]  T360  = TURN_W'(DEG360);
    localparam logic signed [TURN_W-1:0]  T_MAX = 26'sh1ffffff;
    localparam logic signed [TURN_W-1:0]  T_MIN = 26'sh2000000;

    localparam longint ROUND_HALF = 64'sd536870912;

    localparam longint ATAN_DEG [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [COORD_W-1:0] distance;
        logic                      draw_line;
        logic signed [TURN_W-1:0]  turn_degrees;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
    } turtle_cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } turtle_seg_t;

    typedef struct packed {
        turtle_cmd_t item;
        logic        typed;
        turtle_seg_t seg;
    } turtle_row_t;

    localparam turtle_seg_t NO_SEG = '0;

    // typed rows: zero-length draws, where start and end equal the pen
    localparam turtle_row_t DIRECTED [28] = '{
        '{'{CMD_FWD, 32'sd0, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{32'sd0, 32'sd0, 32'sd0, 32'sd0}},
        '{'{CMD_FWD, 32'sd655360, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_UNUSED, -32'sd1, 1'b1, -26'sd1, -32'sd1, -32'sd1}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, -26'sd1, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd655360, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, 26'sd1, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, T90, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, -32'sd327680, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, T180, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd163840, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, 26'sd1, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd65536, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, -T360, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, T360, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, T_MAX, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, T_MIN, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_TURN, 32'sd0, 1'b0, -26'sd11829248, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, C_MAX, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, C_MIN, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd196608, 1'b0, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_SET, 32'sd0, 1'b0, 26'sd0, C_MAX, C_MIN}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd0, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{C_MAX, C_MIN, C_MAX, C_MIN}},
        '{'{CMD_SET, 32'sd0, 1'b0, 26'sd0, C_MIN, C_MAX}, 1'b0, NO_SEG},
        '{'{CMD_FWD, 32'sd0, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b1,
          '{C_MIN, C_MAX, C_MIN, C_MAX}},
        '{'{CMD_TURN, 32'sd0, 1'b0, T45, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, C_MIN, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_SET, 32'sd0, 1'b0, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG},
        '{'{CMD_FWD, -32'sd1, 1'b1, 26'sd0, 32'sd0, 32'sd0}, 1'b0, NO_SEG}
    };

    logic clk;
    logic rst_n;

    tvs_cmd_if cmd_ch ();
    tvs_seg_if seg_ch ();

    turtle_vector_step_top #(
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .seg   (seg_ch)
    );

    longint      trk_x;
    longint      trk_y;
    longint      trk_heading;
    turtle_seg_t pending_segs [$];
    int          n_fail;
    int          burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void cordic_cos_sin(input longint ang, output longint c,
                                           output longint s);
        longint x, y, z, xs, ys;
        bit     flip;
        int     n;
        x = GAIN_Q30;
        y = 0;
        z = ang;
        flip = 1'b0;
        n = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
        if (z > DEG90 && z <= DEG270)
        begin
            z = z - DEG180;
            flip = 1'b1;
        end
        else if (z > DEG270)
        begin
            z = z - DEG360;
        end
        for (int i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // updates the tracked pen and heading; returns 1 when a segment is due
    function automatic bit turtle_apply(input turtle_cmd_t it, output turtle_seg_t seg);
        longint c, s, d, nx, ny, hd;
        bit     drew;
        seg = '0;
        drew = 1'b0;
        case (it.command)
            CMD_FWD:
            begin
                d = $signed(it.distance);
                cordic_cos_sin(trk_heading, c, s);
                nx = clamp_coord(trk_x + ((d * c + ROUND_HALF) >>> FRAC_VEC));
                ny = clamp_coord(trk_y + ((d * s + ROUND_HALF) >>> FRAC_VEC));
                if (it.draw_line)
                begin
                    seg.start_x = trk_x[COORD_W-1:0];
                    seg.start_y = trk_y[COORD_W-1:0];
                    seg.end_x   = nx[COORD_W-1:0];
                    seg.end_y   = ny[COORD_W-1:0];
                    drew = 1'b1;
                end
                trk_x = nx;
                trk_y = ny;
            end
            CMD_TURN:
            begin
                hd = (trk_heading + longint'($signed(it.turn_degrees))) % longint'(DEG360);
                if (hd < 0)
                    hd = hd + DEG360;
                trk_heading = hd;
            end
            CMD_SET:
            begin
                trk_x = $signed(it.target_x);
                trk_y = $signed(it.target_y);
            end
            default:
            begin
            end
        endcase
        return drew;
    endfunction

    function automatic turtle_cmd_t random_command();
        turtle_cmd_t it;
        int          sel;
        sel = $urandom_range(0, 99);
        it.command = (sel < 55) ? CMD_FWD : (sel < 80) ? CMD_TURN :
                     (sel < 96) ? CMD_SET : CMD_UNUSED;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            it.distance = $urandom;
        else if (sel == 1)
            it.distance = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
        else
            it.distance = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        it.draw_line = ($urandom_range(0, 9) < 7);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            it.turn_degrees = TURN_W'((int'($urandom_range(0, 8)) - 4) * int'(DEG90));
        else if (sel == 1)
            it.turn_degrees = ($urandom_range(0, 1) != 0) ? T360 : -T360;
        else
            it.turn_degrees = TURN_W'(int'($urandom_range(0, 2 * DEG360)) - int'(DEG360));
        if ($urandom_range(0, 4) == 0)
        begin
            it.target_x = $urandom;
            it.target_y = $urandom;
        end
        else
        begin
            it.target_x = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            it.target_y = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        end
        return it;
    endfunction

    task automatic send_command(input turtle_cmd_t it, input logic typed,
                                input turtle_seg_t typed_seg);
        int          gap;
        turtle_seg_t seg;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= it.command;
        cmd_ch.distance     <= it.distance;
        cmd_ch.draw_line    <= it.draw_line;
        cmd_ch.turn_degrees <= it.turn_degrees;
        cmd_ch.target_x     <= it.target_x;
        cmd_ch.target_y     <= it.target_y;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (turtle_apply(it, seg))
            pending_segs.push_back(typed ? typed_seg : seg);
    endtask

    task automatic wait_segments_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_segs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_FWD;
        cmd_ch.distance     = '0;
        cmd_ch.draw_line    = 1'b0;
        cmd_ch.turn_degrees = '0;
        cmd_ch.target_x     = '0;
        cmd_ch.target_y     = '0;
        trk_x       = 0;
        trk_y       = 0;
        trk_heading = 0;
        n_fail      = 0;
        burst_left  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
            send_command(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].seg);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 400 || i == 800)
                wait_segments_drained();
            send_command(random_command(), 1'b0, NO_SEG);
        end

        wait_segments_drained();
        repeat (STEPS + 10) @(posedge clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // segment consumer: phases of steady, random, sparse and periodic ready
    initial
    begin : seg_ready_gen
        int mode;
        int phase_left;
        seg_ch.ready = 1'b0;
        phase_left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            case (mode)
                0:       seg_ch.ready <= 1'b1;
                1:       seg_ch.ready <= ($urandom_range(0, 1) != 0);
                2:       seg_ch.ready <= ($urandom_range(0, 7) == 0);
                default: seg_ch.ready <= ((phase_left % 16) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin : seg_check
        turtle_seg_t want;
        if (rst_n && seg_ch.valid && seg_ch.ready)
        begin
            if (pending_segs.size() == 0)
            begin
                $error("segment transaction with none expected: %0d,%0d -> %0d,%0d",
                       seg_ch.start_x, seg_ch.start_y, seg_ch.end_x, seg_ch.end_y);
                n_fail++;
            end
            else
            begin
                want = pending_segs.pop_front();
                if (seg_ch.start_x !== want.start_x)
                begin
                    $error("start_x: expected %0d, got %0d", want.start_x, seg_ch.start_x);
                    n_fail++;
                end
                if (seg_ch.start_y !== want.start_y)
                begin
                    $error("start_y: expected %0d, got %0d", want.start_y, seg_ch.start_y);
                    n_fail++;
                end
                if (seg_ch.end_x !== want.end_x)
                begin
                    $error("end_x: expected %0d, got %0d", want.end_x, seg_ch.end_x);
                    n_fail++;
                end
                if (seg_ch.end_y !== want.end_y)
                begin
                    $error("end_y: expected %0d, got %0d", want.end_y, seg_ch.end_y);
                    n_fail++;
                end
            end
        end
    end

endmodule
